/* hw/rtl/alux_pkg.sv */
package alux_pkg;

  // Field widths
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned LUX_W   = 20;
  localparam int unsigned SEG_W   = 3;
  localparam int unsigned POW_W   = 17;  // k^1.4 in Q16, 1.0 included
  localparam int unsigned LIN_W   = 31;  // dividend of the final divide by LUX_DIV

  // Parameter defaults
  localparam int unsigned RATIO_FRAC_BITS_DEF = 16;
  localparam int unsigned POW_TABLE_DEPTH_DEF = 64;

  // Ratio segment codes
  typedef enum logic [SEG_W-1:0] {
    SEG_POW  = 3'd0,
    SEG_LIN1 = 3'd1,
    SEG_LIN2 = 3'd2,
    SEG_LIN3 = 3'd3,
    SEG_OFF  = 3'd4
  } seg_t;

  // Segment limits, as percent of the broadband count
  localparam int unsigned PCT_SCALE = 100;
  localparam int unsigned LIM_POW   = 52;
  localparam int unsigned LIM_LIN1  = 65;
  localparam int unsigned LIM_LIN2  = 80;
  localparam int unsigned LIM_LIN3  = 130;

  // Formula coefficients in units of 1e-5
  localparam int unsigned CF_POW_B  = 3150;
  localparam int unsigned CF_POW_K  = 5930;
  localparam int unsigned CF_LIN1_B = 2290;
  localparam int unsigned CF_LIN1_I = 2910;
  localparam int unsigned CF_LIN2_B = 1570;
  localparam int unsigned CF_LIN2_I = 1800;
  localparam int unsigned CF_LIN3_B = 338;
  localparam int unsigned CF_LIN3_I = 260;

  // 0.0315 * 2^16 * 1e5, the constant term of the first formula
  localparam logic [27:0] POW_BASE = 28'(CF_POW_B * 65536);

  // lux_q8 = floor(v / LUX_DIV); exact reciprocal for any v below 2^LIN_W
  localparam int unsigned    LUX_DIV    = 3125;
  localparam int unsigned    DIV_SHIFT  = 43;
  localparam logic [63:0]    DIV_RECIP64 = ((64'd1 << DIV_SHIFT) + 64'(LUX_DIV - 1)) / LUX_DIV;
  localparam logic [31:0]    DIV_RECIP  = DIV_RECIP64[31:0];
  localparam int unsigned    POW_SHIFT  = 13;  // 2^16 * 256 / 100000 leaves 1 / (8192 * 3125)

  // Per-item side data that travels with the pipeline
  typedef struct packed {
    logic [COUNT_W-1:0] broad;
    seg_t               seg;
    logic               zb;
    logic [LIN_W-1:0]   lin;
  } side_t;

  // One k^1.4 table entry: x * x^0.4 in Q16, x the Q16 abscissa
  function automatic logic [POW_W-1:0] pow_entry(input logic [31:0] x);
    logic [16:0] lo;
    logic [16:0] hi;
    logic [17:0] sum;
    logic [16:0] mid;
    logic [95:0] w5;
    logic [95:0] rhs;
    logic [63:0] y;
    lo  = '0;
    hi  = 17'd65535;
    rhs = 96'(x) * 96'(x) << 48;
    // largest w with w^5 <= x^2 * 2^48
    for (int n = 0; n < 17; n++) begin
      if (lo < hi) begin
        sum = 18'(lo) + 18'(hi) + 18'd1;
        mid = sum[17:1];
        w5  = 96'(mid) * 96'(mid) * 96'(mid) * 96'(mid) * 96'(mid);
        if (w5 <= rhs) begin
          lo = mid;
        end else begin
          hi = mid - 17'd1;
        end
      end
    end
    y = (64'(x) * 64'(lo)) >> 16;
    if (x >= 32'd65536) begin
      pow_entry = POW_W'(65536);
    end else begin
      pow_entry = y[POW_W-1:0];
    end
  endfunction

endpackage

/* hw/rtl/alux_if.sv */
// Input channel: one pair of light counts per word
interface alux_in_if;
  import alux_pkg::*;

  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] broad_count;
  logic [COUNT_W-1:0] ir_count;

  modport source (output valid, broad_count, ir_count, input ready);
  modport sink   (input valid, broad_count, ir_count, output ready);
endinterface

// Result channel: lux, segment and zero flag per word
interface alux_out_if;
  import alux_pkg::*;

  logic             valid;
  logic             ready;
  logic [LUX_W-1:0] lux_q8;
  logic [SEG_W-1:0] segment;
  logic             zero_broad;

  modport source (output valid, lux_q8, segment, zero_broad, input ready);
  modport sink   (input valid, lux_q8, segment, zero_broad, output ready);
endinterface

/* hw/rtl/ambient_light_lux_calc_core.sv */
// Two-channel ambient light lux calculator. Each input word carries a broadband
// count and an infrared count; each result word carries lux in units of 1/256
// (floored, clamped at zero), the ratio segment used (0..3, or 4 when the
// infrared/broadband ratio is above 1.30 or the broadband count is zero) and a
// zero-broadband flag. The core accepts one word every cycle and returns
// results in order. Each word passes through the input register, the
// restoring ratio divider, one quotient bit per stage, the k^1.4 table
// interpolation, the final reciprocal multiply and the output register.
// The k^1.4 table has POW_TABLE_DEPTH entries and is built as constants
// at elaboration. While a finished result is not taken, the whole
// pipeline holds.
module ambient_light_lux_calc_core #(
  parameter int unsigned RATIO_FRAC_BITS = alux_pkg::RATIO_FRAC_BITS_DEF,
  parameter int unsigned POW_TABLE_DEPTH = alux_pkg::POW_TABLE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  alux_in_if.sink    in_chan,
  alux_out_if.source out_chan
);
  import alux_pkg::*;

  localparam int unsigned FB    = RATIO_FRAC_BITS;
  localparam int unsigned PowM  = POW_TABLE_DEPTH - 1;
  localparam int unsigned IW    = $clog2(POW_TABLE_DEPTH);
  localparam int unsigned NS    = FB + 8;          // side stages from segment choice to the output register
  localparam int unsigned S_P5  = FB + 5;
  localparam int unsigned S_P6  = FB + 6;
  localparam int unsigned S_P7  = FB + 7;

  // Pipeline enable: advance unless a result waits
  logic en;
  logic out_valid_r;
  assign en            = !out_valid_r || out_chan.ready;
  assign in_chan.ready = en;

  // ---------------------------------------------------------------
  // Input register
  logic               vld0_r;
  logic [COUNT_W-1:0] b0_r;
  logic [COUNT_W-1:0] ir0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (en) begin
      vld0_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b0_r  <= in_chan.broad_count;
      ir0_r <= in_chan.ir_count;
    end
  end

  // ---------------------------------------------------------------
  // Segment choice by cross multiplication, linear formulas
  logic [23:0]      ir_pct;
  logic [23:0]      lim_pow;
  logic [23:0]      lim_lin1;
  logic [23:0]      lim_lin2;
  logic [23:0]      lim_lin3;
  logic [27:0]      lin1_pb;
  logic [27:0]      lin1_pi;
  logic [27:0]      lin2_pb;
  logic [27:0]      lin2_pi;
  logic [27:0]      lin3_pb;
  logic [27:0]      lin3_pi;
  logic [LIN_W-1:0] lin1;
  logic [LIN_W-1:0] lin2;
  logic [LIN_W-1:0] lin3;
  side_t            side_nxt;

  assign ir_pct   = 24'(ir0_r) * 24'(PCT_SCALE);
  assign lim_pow  = 24'(b0_r) * 24'(LIM_POW);
  assign lim_lin1 = 24'(b0_r) * 24'(LIM_LIN1);
  assign lim_lin2 = 24'(b0_r) * 24'(LIM_LIN2);
  assign lim_lin3 = 24'(b0_r) * 24'(LIM_LIN3);

  // 256 * N / 100000 = 8 * N / LUX_DIV; clamp negative N at zero
  assign lin1_pb = 28'(CF_LIN1_B) * 28'(b0_r);
  assign lin1_pi = 28'(CF_LIN1_I) * 28'(ir0_r);
  assign lin2_pb = 28'(CF_LIN2_B) * 28'(b0_r);
  assign lin2_pi = 28'(CF_LIN2_I) * 28'(ir0_r);
  assign lin3_pb = 28'(CF_LIN3_B) * 28'(b0_r);
  assign lin3_pi = 28'(CF_LIN3_I) * 28'(ir0_r);
  assign lin1    = (lin1_pb > lin1_pi) ? {28'(lin1_pb - lin1_pi), 3'b000} : '0;
  assign lin2    = (lin2_pb > lin2_pi) ? {28'(lin2_pb - lin2_pi), 3'b000} : '0;
  assign lin3    = (lin3_pb > lin3_pi) ? {28'(lin3_pb - lin3_pi), 3'b000} : '0;

  always_comb begin
    side_nxt.broad = b0_r;
    side_nxt.zb    = (b0_r == '0);
    side_nxt.lin   = '0;
    if (b0_r == '0) begin
      side_nxt.seg = SEG_OFF;
    end else if (ir_pct <= lim_pow) begin
      side_nxt.seg = SEG_POW;
    end else if (ir_pct <= lim_lin1) begin
      side_nxt.seg = SEG_LIN1;
      side_nxt.lin = lin1;
    end else if (ir_pct <= lim_lin2) begin
      side_nxt.seg = SEG_LIN2;
      side_nxt.lin = lin2;
    end else if (ir_pct <= lim_lin3) begin
      side_nxt.seg = SEG_LIN3;
      side_nxt.lin = lin3;
    end else begin
      side_nxt.seg = SEG_OFF;
    end
  end

  // ---------------------------------------------------------------
  // Side data and valid bits travel together
  side_t        side_r [NS];
  logic [NS-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS-2:0], vld0_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_nxt;
      for (int s = 1; s < NS; s++) begin
        side_r[s] <= side_r[s-1];
      end
    end
  end

  // ---------------------------------------------------------------
  // Restoring divider: k = (ir << FB) / broad, one bit per stage.
  // Only used in the first segment, where ir < broad keeps k below 1.0.
  logic [COUNT_W-1:0] rem_r [FB];
  logic [FB-1:0]      quo_r [FB+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= ir0_r;
      quo_r[0] <= '0;
    end
  end

  for (genvar j = 0; j < FB; j++) begin : g_div
    logic [COUNT_W:0] r2;
    logic [COUNT_W:0] dsor;
    logic             ge;
    assign r2   = {rem_r[j], 1'b0};
    assign dsor = {1'b0, side_r[j].broad};
    assign ge   = (r2 >= dsor);
    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[j+1] <= {quo_r[j][FB-2:0], ge};
      end
    end
    // Hand the partial remainder to the next stage
    if (j < FB - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j+1] <= ge ? COUNT_W'(r2 - dsor) : r2[COUNT_W-1:0];
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // k^1.4 table, built at elaboration
  logic [POW_W-1:0] pow_tab [POW_TABLE_DEPTH];

  for (genvar i = 0; i < POW_TABLE_DEPTH; i++) begin : g_tab
    localparam logic [31:0] XI = (32'(i) << 16) / 32'(PowM);
    assign pow_tab[i] = pow_entry(XI);
  end

  // P1: scale k by the table span
  logic [FB+IW-1:0] p1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r <= (FB+IW)'(quo_r[FB]) * (FB+IW)'(PowM);
    end
  end

  // P2: read both neighbors
  logic [IW-1:0]    idx1;
  logic [IW-1:0]    idx1_inc;
  logic [POW_W-1:0] ta2_r;
  logic [POW_W-1:0] tb2_r;
  logic [FB-1:0]    fr2_r;

  assign idx1     = p1_r[FB+IW-1:FB];
  assign idx1_inc = idx1 + IW'(1);

  always_ff @(posedge clk) begin
    if (en) begin
      ta2_r <= pow_tab[idx1];
      tb2_r <= pow_tab[idx1_inc];
      fr2_r <= p1_r[FB-1:0];
    end
  end

  // P3: slope times fraction
  logic [POW_W-1:0]    dlt2;
  logic [POW_W+FB-1:0] prod3_r;
  logic [POW_W-1:0]    ta3_r;

  assign dlt2 = (tb2_r >= ta2_r) ? POW_W'(tb2_r - ta2_r) : '0;

  always_ff @(posedge clk) begin
    if (en) begin
      prod3_r <= (POW_W+FB)'(dlt2) * (POW_W+FB)'(fr2_r);
      ta3_r   <= ta2_r;
    end
  end

  // P4: interpolated k^1.4
  logic [POW_W-1:0] pw4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pw4_r <= POW_W'(ta3_r + prod3_r[POW_W+FB-1:FB]);
    end
  end

  // P5: per-count term of the first formula, clamp at zero
  logic [29:0] pw_term;
  logic [27:0] c5_r;
  logic        cpos5_r;

  assign pw_term = 30'(pw4_r) * 30'(CF_POW_K);

  always_ff @(posedge clk) begin
    if (en) begin
      cpos5_r <= (30'(POW_BASE) > pw_term);
      c5_r    <= 28'(30'(POW_BASE) - pw_term);
    end
  end

  // P6: scale by the broadband count
  logic [43:0] num6_r;
  logic        cpos6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      num6_r  <= 44'(side_r[S_P5].broad) * 44'(c5_r);
      cpos6_r <= cpos5_r;
    end
  end

  // P7: select the dividend, multiply by the reciprocal of LUX_DIV
  logic [LIN_W-1:0] dvd7;
  logic [62:0]      mul7_r;

  always_comb begin
    case (side_r[S_P6].seg) inside
      SEG_POW: begin
        dvd7 = cpos6_r ? num6_r[POW_SHIFT +: LIN_W] : '0;
      end
      SEG_LIN1, SEG_LIN2, SEG_LIN3: begin
        dvd7 = side_r[S_P6].lin;
      end
      default: begin
        dvd7 = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mul7_r <= 63'(dvd7) * 63'(DIV_RECIP);
    end
  end

  // ---------------------------------------------------------------
  // Output register; quotient stays below 2^LUX_W for every dividend
  logic [LUX_W-1:0] out_lux_r;
  logic [SEG_W-1:0] out_seg_r;
  logic             out_zb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_lux_r <= mul7_r[DIV_SHIFT +: LUX_W];
      out_seg_r <= side_r[S_P7].seg;
      out_zb_r  <= side_r[S_P7].zb;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.lux_q8     = out_lux_r;
  assign out_chan.segment    = out_seg_r;
  assign out_chan.zero_broad = out_zb_r;

endmodule
